// ===== sv/modular_exponentiation_defines.svh =====
// Assertion macros for the modular exponentiation block.
// Used by the top level only; set NO_ASSERTIONS to compile them away.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Hold expr at every edge outside reset.
`define MX_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// When ante holds, cons must hold at the next edge.
`define MX_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MX_ASSERT(name, expr, msg)
`define MX_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== sv/modexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by the controller, datapath and top level.
package modexp_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned REG_IDX_W     = 1;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MODULUS  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture exponent, seed accumulator
    logic start_red;  // start 1 * message (reduces message mod modulus)
    logic start_mul;  // start acc * base
    logic start_sq;   // start base * base
    logic cap_base;   // take product into base
    logic cap_acc;    // take product into accumulator
    logic shift_exp;  // drop the exponent bit just used
    logic out_load;   // move accumulator into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mul_busy;
    logic exp_lsb;
    logic exp_zero;
    logic small_mod;  // modulus of zero or one
  } sts_t;

endpackage

// ===== sv/modexp_mulmod.sv =====
// Bit-serial modular multiplier with interleaved reduction, one bit per cycle.
// Standalone; instantiated by modexp_dp.
module modexp_mulmod #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] modulus,
  output logic                 busy,
  output logic [WORD_BITS-1:0] product
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] r;
  logic [WORD_BITS-1:0] a_q;
  logic [WORD_BITS-1:0] b_q;
  logic [CNT_W-1:0]     cnt;

  logic [WORD_BITS:0]   s_dbl;
  logic [WORD_BITS-1:0] r_dbl;
  logic [WORD_BITS:0]   s_add;
  logic [WORD_BITS-1:0] r_next;

  // Double, reduce, then conditionally add a and reduce again
  always_comb begin
    s_dbl = {1'b0, r} + {1'b0, r};
    if (s_dbl >= {1'b0, modulus}) begin
      s_dbl = s_dbl - {1'b0, modulus};
    end
    r_dbl = s_dbl[WORD_BITS-1:0];
    s_add = {1'b0, r_dbl} + (b_q[WORD_BITS-1] ? {1'b0, a_q} : '0);
    if (s_add >= {1'b0, modulus}) begin
      s_add = s_add - {1'b0, modulus};
    end
    r_next = s_add[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(WORD_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= '0;
      a_q <= a;
      b_q <= b;
    end else if (busy) begin
      r   <= r_next;
      b_q <= b_q << 1;
    end
  end

  assign product = r;

endmodule

// ===== sv/modexp_dp.sv =====
// Datapath: accumulator, base, exponent shifter and the shared multiplier.
// Depends on modexp_pkg and modexp_mulmod.
module modexp_dp
  import modexp_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [WORD_BITS-1:0] message,
  input  logic [WORD_BITS-1:0] exponent,
  input  logic [WORD_BITS-1:0] modulus,
  output sts_t                 sts,
  output logic [WORD_BITS-1:0] acc
);

  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] exp_sh;
  logic [WORD_BITS-1:0] op_a;
  logic [WORD_BITS-1:0] op_b;
  logic [WORD_BITS-1:0] product;
  logic                 mul_start;
  logic                 mul_busy;

  assign mul_start = cmd.start_red | cmd.start_mul | cmd.start_sq;

  always_comb begin
    op_a = base;
    op_b = base;
    if (cmd.start_red) begin
      op_a = WORD_BITS'(1);
      op_b = message;
    end else if (cmd.start_mul) begin
      op_a = acc;
    end
  end

  modexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (op_a),
    .b      (op_b),
    .modulus(modulus),
    .busy   (mul_busy),
    .product(product)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc    <= sts.small_mod ? '0 : WORD_BITS'(1);
      exp_sh <= exponent;
    end else begin
      if (cmd.cap_acc) begin
        acc <= product;
      end
      if (cmd.shift_exp) begin
        exp_sh <= exp_sh >> 1;
      end
    end
    if (cmd.cap_base) begin
      base <= product;
    end
  end

  always_comb begin
    sts.mul_busy  = mul_busy;
    sts.exp_lsb   = exp_sh[0];
    sts.exp_zero  = (exp_sh == '0);
    sts.small_mod = (modulus <= WORD_BITS'(1));
  end

endmodule

// ===== sv/modexp_ctrl.sv =====
// Controller: sequences reduction, multiply and square rounds per request.
// Depends on modexp_pkg.
module modexp_ctrl
  import modexp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_MUL    = 6'b001000,
    S_SQ     = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.small_mod) begin
            state_next = S_DONE;
          end else begin
            cmd.start_red = 1'b1;
            state_next    = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (!sts.mul_busy) begin
          cmd.cap_base = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.exp_zero) begin
          state_next = S_DONE;
        end else if (sts.exp_lsb) begin
          cmd.start_mul = 1'b1;
          state_next    = S_MUL;
        end else begin
          cmd.start_sq = 1'b1;
          state_next   = S_SQ;
        end
      end
      S_MUL: begin
        if (!sts.mul_busy) begin
          cmd.cap_acc  = 1'b1;
          cmd.start_sq = 1'b1;
          state_next   = S_SQ;
        end
      end
      S_SQ: begin
        if (!sts.mul_busy) begin
          cmd.cap_base  = 1'b1;
          cmd.shift_exp = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/modular_exponentiation.sv =====
// Modular exponentiation: power_result = message ^ exponent mod modulus.
// Depends on modexp_pkg, modexp_ctrl, modexp_dp and the assertion header.
//
// Usage: write the exponent (index 0) and modulus (index 1) through the
// cfg_we / cfg_index / cfg_data port while the block is idle. Send one
// request per message on the s_* stream; one result per request leaves on
// the m_* stream, in order.
// Sequence: each modular multiplication occupies the shared bit-serial
// multiplier. A request runs one reduction of the message, then for each
// exponent bit up to the highest set bit a multiply if the bit is set and
// a square. A modulus of zero or one skips all rounds and returns 0.
// Throughput: one request at a time; s_tready is high only while idle.
// The finished result sits in an output register, so a new request is
// taken while the previous result still waits for m_tready.
// Reset: exponent and modulus return to 1, the sequence and the output
// valid flag are cleared. A stalled receiver holds the result in place;
// the next result waits until the output register drains.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [8*((WORD_BITS+7)/8)-1:0] s_tdata,   // [WORD_BITS-1:0] message
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [8*((WORD_BITS+7)/8)-1:0] m_tdata,   // [WORD_BITS-1:0] power_result
  // configuration writes
  input  logic                           cfg_we,
  input  logic [REG_IDX_W-1:0]           cfg_index,
  input  logic [WORD_BITS-1:0]           cfg_data
);

  logic [WORD_BITS-1:0] exponent;
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] out_q;
  logic                 out_valid;
  logic                 out_free;
  cmd_t                 cmd;
  sts_t                 sts;

  // Configuration registers; to be written only while idle, a rule the user keeps, unchecked by the block
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= WORD_BITS'(1);
      modulus  <= WORD_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPONENT: exponent <= cfg_data;
        REG_MODULUS:  modulus  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Free when empty, or when the held result leaves this cycle
  assign out_free = !out_valid || m_tready;

  modexp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .out_free(out_free),
    .sts     (sts),
    .cmd     (cmd)
  );

  modexp_dp #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .message (s_tdata[WORD_BITS-1:0]),
    .exponent(exponent),
    .modulus (modulus),
    .sts     (sts),
    .acc     (acc)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_q <= acc;
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    m_tdata                = '0;
    m_tdata[WORD_BITS-1:0] = out_q;
  end

  // A new result never lands on one that is still waiting
  `MX_ASSERT(a_no_overwrite, !(cmd.out_load && out_valid && !m_tready), "result overwritten")
  // Every loaded result is a residue of a nonzero modulus
  `MX_ASSERT(a_residue, !cmd.out_load || (modulus == '0) || (acc < modulus), "result not reduced")
  // One request at a time: ready drops right after a request is taken
  `MX_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request overlap")

endmodule
